>>> design/bbd_pkg.sv
package bbd_pkg;

    localparam int BIN_W       = 15;
    localparam int LEVEL_W     = 11;
    localparam int WIN_W       = 8;
    localparam int CNT_W       = 9;
    localparam int MAX_BINS    = 5;
    localparam int BIN_SHIFT   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 11'd2047;
    localparam logic [WIN_W-1:0]   WINDOW_RESET = 8'd10;

    // hysteresis thresholds: (6*max + 4*min) / 10 and (4*max + 6*min) / 10
    localparam int HYST_DIV    = 10;
    localparam int HYST_HI_WT  = 6;
    localparam int HYST_LO_WT  = 4;
    localparam int MIX_W       = 15;
    localparam int DIV_SHIFT   = MIX_W + $clog2(HYST_DIV);
    localparam int RECIP_W     = DIV_SHIFT - $clog2(HYST_DIV) + 2;
    localparam int DIV_PROD_W  = MIX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] HYST_RECIP =
        RECIP_W'(((longint'(1) << DIV_SHIFT) + HYST_DIV - 1) / HYST_DIV);

    typedef struct packed {
        logic               beat;
        logic               armed;
        logic [LEVEL_W-1:0] level;
    } result_t;

    function automatic logic [LEVEL_W-1:0] hyst_div(input logic [MIX_W-1:0] x);
        logic [DIV_PROD_W-1:0] prod;
        prod = DIV_PROD_W'(x) * DIV_PROD_W'(HYST_RECIP);
        return LEVEL_W'(prod >> DIV_SHIFT);
    endfunction

endpackage

>>> design/bass_beat_detector.sv
// Bass beat detector. Takes one spectrum beat per cycle while m_ready does not hold the output
// back, and returns one result beat for each, in order. The bin sum is registered at the edge
// that accepts a beat. The level (sum divided by twice the bin count) is then written to a
// two-entry queue, and from there the back end updates the running max/min, window swap and
// hysteresis thresholds and registers the result. The back end's state update keeps the rate
// at one beat per cycle unless the output stalls. window_frames resets to 10 and is written by
// cfg_we/cfg_wdata; the user must write it only while idle, as the block does not enforce this.
module bass_beat_detector
    import bbd_pkg::*;
#(
    parameter int BINS_PER_CHANNEL = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BIN_W-1:0]   s_left_bin0,
    input  logic [BIN_W-1:0]   s_left_bin1,
    input  logic [BIN_W-1:0]   s_left_bin2,
    input  logic [BIN_W-1:0]   s_left_bin3,
    input  logic [BIN_W-1:0]   s_left_bin4,
    input  logic [BIN_W-1:0]   s_right_bin0,
    input  logic [BIN_W-1:0]   s_right_bin1,
    input  logic [BIN_W-1:0]   s_right_bin2,
    input  logic [BIN_W-1:0]   s_right_bin3,
    input  logic [BIN_W-1:0]   s_right_bin4,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_beat,
    output logic               m_beat_armed_off,
    output logic [LEVEL_W-1:0] m_bass_level,
    input  logic               cfg_we,
    input  logic [WIN_W-1:0]   cfg_wdata
);

    logic [BIN_W-1:0]   left_bins  [MAX_BINS];
    logic [BIN_W-1:0]   right_bins [MAX_BINS];
    logic [WIN_W-1:0]   window_reg;
    logic               f_valid, f_ready;
    logic [LEVEL_W-1:0] f_level;
    logic               q_valid, q_ready;
    logic [LEVEL_W-1:0] q_level;
    result_t            result;

    assign left_bins[0]  = s_left_bin0;
    assign left_bins[1]  = s_left_bin1;
    assign left_bins[2]  = s_left_bin2;
    assign left_bins[3]  = s_left_bin3;
    assign left_bins[4]  = s_left_bin4;
    assign right_bins[0] = s_right_bin0;
    assign right_bins[1] = s_right_bin1;
    assign right_bins[2] = s_right_bin2;
    assign right_bins[3] = s_right_bin3;
    assign right_bins[4] = s_right_bin4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_we) begin
            window_reg <= cfg_wdata;
        end
    end

    bbd_front #(
        .BINS_PER_CHANNEL(BINS_PER_CHANNEL)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .left_bins (left_bins),
        .right_bins(right_bins),
        .lvl_valid (f_valid),
        .lvl_ready (f_ready),
        .lvl_data  (f_level)
    );

    bbd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  (f_level),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_level)
    );

    bbd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_level     (q_level),
        .window_frames(window_reg),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_result   (result)
    );

    assign m_beat           = result.beat;
    assign m_beat_armed_off = result.armed;
    assign m_bass_level     = result.level;

    // upper threshold never below lower one, so a fresh beat stays armed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beat |-> m_beat_armed_off)
        else $error("beat reported while disarmed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beat |-> m_bass_level != '0)
        else $error("beat on zero level");

    assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid && !f_ready |-> q_valid)
        else $error("queue stalls front while empty");

endmodule

>>> design/bbd_front.sv
module bbd_front
    import bbd_pkg::*;
#(
    parameter int BINS_PER_CHANNEL = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BIN_W-1:0]   left_bins  [MAX_BINS],
    input  logic [BIN_W-1:0]   right_bins [MAX_BINS],
    output logic               lvl_valid,
    input  logic               lvl_ready,
    output logic [LEVEL_W-1:0] lvl_data
);

    localparam int DIVISOR     = 2 * BINS_PER_CHANNEL;
    localparam int SUM_MAX     = DIVISOR * (((2 ** BIN_W) - 1) >> BIN_SHIFT);
    localparam int SUM_W       = $clog2(SUM_MAX + 1);
    localparam int RECIP_SHIFT = SUM_W + $clog2(DIVISOR);
    localparam int PROD_W      = SUM_W + RECIP_SHIFT + 1;
    localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              vld_reg, vld_next;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  lvl_full;

    // shifted magnitudes, paired per bin then summed
    always_comb begin
        logic [SUM_W-1:0] pair;
        sum_next = '0;
        for (int i = 0; i < BINS_PER_CHANNEL; i++) begin
            pair = SUM_W'(left_bins[i] >> BIN_SHIFT) + SUM_W'(right_bins[i] >> BIN_SHIFT);
            sum_next = sum_next + pair;
        end
    end

    assign s_ready  = !vld_reg || lvl_ready;
    assign vld_next = s_ready ? s_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sum_reg <= sum_next;
        end
    end

    // divide by twice the bin count through reciprocal multiply
    assign prod     = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign lvl_full = SUM_W'(prod >> RECIP_SHIFT);

    assign lvl_valid = vld_reg;
    assign lvl_data  = (lvl_full > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(lvl_full);

endmodule

>>> design/bbd_queue.sv
module bbd_queue
    import bbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [LEVEL_W-1:0] in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEVEL_W-1:0] out_data
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [LEVEL_W-1:0] head_reg, head_next;
    logic [LEVEL_W-1:0] tail_reg, tail_next;
    logic               push, pop;

    assign out_valid = (occ_reg != '0);
    assign in_ready  = (occ_reg != OCC_W'(QUEUE_DEPTH)) || out_ready;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = head_reg;

    always_comb begin
        occ_next  = occ_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (push && pop) begin
            if (occ_reg == OCC_W'(1)) begin
                head_next = in_data;
            end else begin
                head_next = tail_reg;
                tail_next = in_data;
            end
        end else if (push) begin
            if (occ_reg == '0) begin
                head_next = in_data;
            end else begin
                tail_next = in_data;
            end
            occ_next = occ_reg + OCC_W'(1);
        end else if (pop) begin
            head_next = tail_reg;
            occ_next  = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

>>> design/bbd_back.sv
module bbd_back
    import bbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [LEVEL_W-1:0] in_level,
    input  logic [WIN_W-1:0]   window_frames,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            out_result
);

    logic [LEVEL_W-1:0] peak_run_reg, peak_run_next;
    logic [LEVEL_W-1:0] max_prev_reg, max_prev_next;
    logic [LEVEL_W-1:0] floor_run_reg, floor_run_next;
    logic [LEVEL_W-1:0] min_prev_reg, min_prev_next;
    logic [CNT_W-1:0]   frames_reg, frames_next;
    logic               active_reg, active_next;
    logic               valid_reg, valid_next;
    result_t            result_reg, result_next;

    logic               take;
    logic               swap;
    logic [LEVEL_W-1:0] max_upd, min_upd;
    logic [MIX_W-1:0]   mix_hi, mix_lo;
    logic [LEVEL_W-1:0] thr_hi, thr_lo;
    logic               fire;
    logic               armed_mid;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        max_upd = (in_level > peak_run_reg) ? in_level : peak_run_reg;
        min_upd = (in_level < floor_run_reg) ? in_level : floor_run_reg;
        swap    = frames_reg > CNT_W'(window_frames);

        max_prev_next  = swap ? max_upd : max_prev_reg;
        min_prev_next  = swap ? min_upd : min_prev_reg;
        peak_run_next  = swap ? '0 : max_upd;
        floor_run_next = swap ? LEVEL_MAX : min_upd;
        frames_next    = swap ? CNT_W'(1) : frames_reg + CNT_W'(1);

        mix_hi = MIX_W'(max_prev_next) * MIX_W'(HYST_HI_WT)
               + MIX_W'(min_prev_next) * MIX_W'(HYST_LO_WT);
        mix_lo = MIX_W'(max_prev_next) * MIX_W'(HYST_LO_WT)
               + MIX_W'(min_prev_next) * MIX_W'(HYST_HI_WT);
        thr_hi = hyst_div(mix_hi);
        thr_lo = hyst_div(mix_lo);

        // trigger and re-arm are both evaluated within one frame
        fire        = (in_level > thr_hi) && !active_reg;
        armed_mid   = fire || active_reg;
        active_next = (in_level < thr_lo) ? 1'b0 : armed_mid;

        result_next.beat  = fire;
        result_next.armed = active_next;
        result_next.level = in_level;

        valid_next = take ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_run_reg  <= '0;
            max_prev_reg  <= '0;
            floor_run_reg <= LEVEL_MAX;
            min_prev_reg  <= '0;
            frames_reg    <= '0;
            active_reg    <= 1'b0;
            valid_reg     <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                peak_run_reg  <= peak_run_next;
                max_prev_reg  <= max_prev_next;
                floor_run_reg <= floor_run_next;
                min_prev_reg  <= min_prev_next;
                frames_reg    <= frames_next;
                active_reg    <= active_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bbd_pkg::*;

    localparam int BINS        = 5;
    localparam int BIN_MAX     = (1 << BIN_W) - 1;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        logic [BINS-1:0][BIN_W-1:0] left;
        logic [BINS-1:0][BIN_W-1:0] right;
        int                         gap;
    } frame_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [BIN_W-1:0]   s_left_bin0 = '0;
    logic [BIN_W-1:0]   s_left_bin1 = '0;
    logic [BIN_W-1:0]   s_left_bin2 = '0;
    logic [BIN_W-1:0]   s_left_bin3 = '0;
    logic [BIN_W-1:0]   s_left_bin4 = '0;
    logic [BIN_W-1:0]   s_right_bin0 = '0;
    logic [BIN_W-1:0]   s_right_bin1 = '0;
    logic [BIN_W-1:0]   s_right_bin2 = '0;
    logic [BIN_W-1:0]   s_right_bin3 = '0;
    logic [BIN_W-1:0]   s_right_bin4 = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_beat;
    logic               m_beat_armed_off;
    logic [LEVEL_W-1:0] m_bass_level;
    logic               cfg_we = 1'b0;
    logic [WIN_W-1:0]   cfg_wdata = '0;

    bass_beat_detector #(
        .BINS_PER_CHANNEL(BINS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_left_bin0     (s_left_bin0),
        .s_left_bin1     (s_left_bin1),
        .s_left_bin2     (s_left_bin2),
        .s_left_bin3     (s_left_bin3),
        .s_left_bin4     (s_left_bin4),
        .s_right_bin0    (s_right_bin0),
        .s_right_bin1    (s_right_bin1),
        .s_right_bin2    (s_right_bin2),
        .s_right_bin3    (s_right_bin3),
        .s_right_bin4    (s_right_bin4),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_beat          (m_beat),
        .m_beat_armed_off(m_beat_armed_off),
        .m_bass_level    (m_bass_level),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    // detector state as the block should hold it
    logic [WIN_W-1:0]   window_frames = WINDOW_RESET;
    logic [LEVEL_W-1:0] peak_run = '0;
    logic [LEVEL_W-1:0] max_previous = '0;
    logic [LEVEL_W-1:0] floor_run = LEVEL_MAX;
    logic [LEVEL_W-1:0] min_previous = '0;
    logic [CNT_W-1:0]   frames_since_swap = '0;
    logic               beat_active = 1'b0;

    frame_t  pending_frames[$];
    result_t expected_reports[$];
    frame_t  staged_frame;
    frame_t  cur_frame;
    bit      staged = 1'b0;
    int      frames_total = 0;
    int      frames_accepted = 0;
    int      mismatches = 0;
    int      send_calm = 0;
    int      recv_calm = 0;
    int      stall_left = 0;
    int      idle_cycles = 0;
    result_t got;
    result_t want;

    int directed_bins [0:23] = '{
        0, BIN_MAX, 15, 16, 'h5555, 'h2AAA, BIN_MAX, 0, BIN_MAX, 0, 16000, 0,
        BIN_MAX, 16000, 0, 16000, BIN_MAX, BIN_MAX, 0, 16000, 13000, BIN_MAX, 0, 16
    };

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic frame_t make_frame(input int lo, input int hi);
        frame_t f;
        int     i;
        for (i = 0; i < BINS; i++) begin
            f.left[i]  = BIN_W'($urandom_range(lo, hi));
            f.right[i] = BIN_W'($urandom_range(lo, hi));
        end
        f.gap = 0;
        return f;
    endfunction

    // bass level, window swap and hysteresis for one accepted frame
    task automatic track_bass_frame(input frame_t f);
        int      sum;
        int      level;
        int      hi_mark;
        int      lo_mark;
        int      i;
        logic    fired;
        result_t r;
        sum = 0;
        for (i = 0; i < BINS; i++)
            sum += int'(f.left[i] >> BIN_SHIFT) + int'(f.right[i] >> BIN_SHIFT);
        level = sum / (2 * BINS);
        if (level > int'(LEVEL_MAX))
            level = int'(LEVEL_MAX);

        if (level > int'(peak_run))
            peak_run = LEVEL_W'(level);
        if (level < int'(floor_run))
            floor_run = LEVEL_W'(level);

        if (frames_since_swap > CNT_W'(window_frames)) begin
            max_previous      = peak_run;
            peak_run          = '0;
            min_previous      = floor_run;
            floor_run         = LEVEL_MAX;
            frames_since_swap = '0;
        end

        hi_mark = (int'(max_previous) * HYST_HI_WT + int'(min_previous) * HYST_LO_WT) / HYST_DIV;
        lo_mark = (int'(max_previous) * HYST_LO_WT + int'(min_previous) * HYST_HI_WT) / HYST_DIV;

        fired = 1'b0;
        if (level > hi_mark && !beat_active) begin
            fired       = 1'b1;
            beat_active = 1'b1;
        end
        if (level < lo_mark && beat_active)
            beat_active = 1'b0;

        frames_since_swap = frames_since_swap + 1'b1;

        r.beat  = fired;
        r.armed = beat_active;
        r.level = LEVEL_W'(level);
        expected_reports.push_back(r);
    endtask

    task automatic queue_frame(input frame_t f);
        f.gap = draw_wait(send_calm);
        pending_frames.push_back(f);
        frames_total++;
    endtask

    // loud frames on a period over a quiet floor, with some mid frames and noise
    task automatic queue_song(input int count);
        int k;
        int period;
        int quiet;
        int loud;
        int mid;
        period = 2;
        quiet  = 0;
        loud   = 0;
        for (k = 0; k < count; k++) begin
            if (k % 120 == 0) begin
                period = $urandom_range(2, 24);
                quiet  = $urandom_range(0, 12000);
                loud   = $urandom_range(quiet, BIN_MAX);
            end
            mid = (quiet + loud) / 2;
            if ($urandom_range(0, 9) == 0)
                queue_frame(make_frame(0, BIN_MAX));
            else if (k % period == 0)
                queue_frame(make_frame(loud - loud / 8, loud));
            else if (k % period == 1 && $urandom_range(0, 1) == 0)
                queue_frame(make_frame(mid - mid / 8, mid));
            else
                queue_frame(make_frame(quiet - quiet / 8, quiet));
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (frames_accepted != frames_total || expected_reports.size() != 0);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] frames);
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= frames;
        @(posedge aclk);
        window_frames = frames;
        cfg_we <= 1'b0;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_bass_frame(cur_frame);
                frames_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (!staged && pending_frames.size() != 0) begin
                    staged_frame = pending_frames.pop_front();
                    staged       = 1'b1;
                end
                if (staged && staged_frame.gap != 0) begin
                    staged_frame.gap--;
                    s_valid <= 1'b0;
                end else if (staged) begin
                    cur_frame = staged_frame;
                    staged    = 1'b0;
                    s_left_bin0  <= cur_frame.left[0];
                    s_left_bin1  <= cur_frame.left[1];
                    s_left_bin2  <= cur_frame.left[2];
                    s_left_bin3  <= cur_frame.left[3];
                    s_left_bin4  <= cur_frame.left[4];
                    s_right_bin0 <= cur_frame.right[0];
                    s_right_bin1 <= cur_frame.right[1];
                    s_right_bin2 <= cur_frame.right[2];
                    s_right_bin3 <= cur_frame.right[3];
                    s_right_bin4 <= cur_frame.right[4];
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.beat  = m_beat;
                got.armed = m_beat_armed_off;
                got.level = m_bass_level;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat: beat=%0d armed=%0d level=%0d",
                                 got.beat, got.armed, got.level);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.beat !== want.beat || got.armed !== want.armed ||
                        got.level !== want.level) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: beat %0d/%0d armed %0d/%0d level %0d/%0d (exp/act)",
                                     want.beat, got.beat, want.armed, got.armed,
                                     want.level, got.level);
                    end
                end
                stall_left = draw_wait(recv_calm);
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on stalled progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL bass_beat_detector");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_bins[k])
            queue_frame(make_frame(directed_bins[k], directed_bins[k]));
        queue_song(300);

        set_window(8'd255);
        queue_song(400);
        set_window(8'd0);
        queue_song(150);
        set_window(8'd1);
        queue_song(150);
        repeat (4) begin
            set_window(WIN_W'($urandom_range(2, 64)));
            queue_song(200);
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("PASS bass_beat_detector");
        end else begin
            $display("FAIL bass_beat_detector");
        end
        $finish;
    end

endmodule
